[hw/rtl/clamped_edge_convolution_3x3_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the clamped edge convolution unit
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef CLAMPED_EDGE_CONVOLUTION_3X3_UNIT_DEFINES_SVH
`define CLAMPED_EDGE_CONVOLUTION_3X3_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// check that is switched off while reset is held
`define CECV_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// check that holds in every cycle, reset included
`define CECV_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define CECV_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define CECV_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

[hw/rtl/cecv_pkg.sv]
// ---------------------------------------------------------------------------
// cecv_pkg
// Shared constants, register codes and types of the convolution unit.
// ---------------------------------------------------------------------------
package cecv_pkg;

  // sizes
  localparam int unsigned MAX_WIDTH      = 1024;
  localparam int unsigned MAX_MASK       = 3;
  localparam int unsigned COEF_FRAC_BITS = 8;
  localparam int unsigned HEIGHT_CAP     = 1024;
  localparam int unsigned ROW_SAT        = 2047;

  // field widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned MASK_W     = 2;
  localparam int unsigned IDX_W      = 20;
  localparam int unsigned BIAS_W     = 13;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 3;

  // register reset values
  localparam logic [DIM_W-1:0]      RST_WIDTH    = 11'd64;
  localparam logic [DIM_W-1:0]      RST_HEIGHT   = 11'd64;
  localparam logic [MASK_W-1:0]     RST_MASK     = 2'd3;
  localparam logic [CFG_DATA_W-1:0] RST_COEF_MID = 48'd256;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_MASK_WIDTH      = 3'd2,
    REG_MASK_HEIGHT     = 3'd3,
    REG_COEF_ROW_TOP    = 3'd4,
    REG_COEF_ROW_MID    = 3'd5,
    REG_COEF_ROW_BOTTOM = 3'd6,
    REG_BIAS            = 3'd7
  } cfg_reg_t;

  // divider status towards the top level
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hw/rtl/clamped_edge_convolution_3x3_unit.sv]
// ---------------------------------------------------------------------------
// clamped_edge_convolution_3x3_unit
// 3x3 convolution with replicated borders over a raster pixel stream.
// ---------------------------------------------------------------------------
// Usage:
//  in_*  : one item per beat; in_tuser is the kind (0 pixel, 1 flush),
//          in_tdata the pixel. Frames enter in raster order.
//  out_* : out_tdata is the filtered pixel, out_tlast marks the frame's last.
//  cfg_* : register writes, index 0..7, always ready; write while idle.
// Throughput: one item per clock unless the output stalls or the divider is
//  busy. The result of a pixel is released by the item arriving W+1 items
//  later (next-frame pixels or flush items), then passes through stages 1 to 5.
//  Flush items before the frame's last pixel are dropped silently.
// A write to image_width re-derives the output row and column with a
//  bit-serial divider: in_tready is low after that write until it finishes.
// Stalls: a five-register pipeline with per-stage ready; items keep being
//  taken while empty stages remain behind a stalled output.
// Reset: counters, window and pipeline clear at once; the two line stores
//  keep their content and get no clearing pass.
// ---------------------------------------------------------------------------
`include "clamped_edge_convolution_3x3_unit_defines.svh"

module clamped_edge_convolution_3x3_unit #(
  parameter int unsigned MAX_WIDTH = cecv_pkg::MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_in
  input  logic [0:0]  in_tuser,   // [0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] pixel_out
  output logic        out_tlast,  // last
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cecv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cecv_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WCAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
  localparam int unsigned CMPW = 13;
  localparam int unsigned PW   = cecv_pkg::PIX_W;
  localparam int unsigned DW   = cecv_pkg::DIM_W;
  localparam int unsigned QW   = cecv_pkg::IDX_W;
  localparam int unsigned CFW  = cecv_pkg::COEF_W;
  localparam int unsigned FB   = cecv_pkg::COEF_FRAC_BITS;
  localparam logic signed [28:0] TRUNC_ADJ = 29'((1 << FB) - 1);

  typedef struct packed {
    logic r_top;
    logic r_bot;
    logic c_left;
    logic c_right;
  } edge_flags_t;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [DW-1:0]                      width_r, height_r;
  logic [cecv_pkg::MASK_W-1:0]        mwidth_r, mheight_r;
  logic [cecv_pkg::CFG_DATA_W-1:0]    coef_r [3];
  logic signed [cecv_pkg::BIAS_W-1:0] bias_r;
  logic                               start_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= cecv_pkg::RST_WIDTH;
      height_r  <= cecv_pkg::RST_HEIGHT;
      mwidth_r  <= cecv_pkg::RST_MASK;
      mheight_r <= cecv_pkg::RST_MASK;
      coef_r[0] <= '0;
      coef_r[1] <= cecv_pkg::RST_COEF_MID;
      coef_r[2] <= '0;
      bias_r    <= '0;
      start_r   <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cecv_pkg::cfg_reg_t'(cfg_index))
          cecv_pkg::REG_IMAGE_WIDTH: begin
            width_r <= cfg_data[DW-1:0];
            start_r <= 1'b1;
          end
          cecv_pkg::REG_IMAGE_HEIGHT:    height_r  <= cfg_data[DW-1:0];
          cecv_pkg::REG_MASK_WIDTH:      mwidth_r  <= cfg_data[1:0];
          cecv_pkg::REG_MASK_HEIGHT:     mheight_r <= cfg_data[1:0];
          cecv_pkg::REG_COEF_ROW_TOP:    coef_r[0] <= cfg_data;
          cecv_pkg::REG_COEF_ROW_MID:    coef_r[1] <= cfg_data;
          cecv_pkg::REG_COEF_ROW_BOTTOM: coef_r[2] <= cfg_data;
          cecv_pkg::REG_BIAS:            bias_r    <= signed'(cfg_data[12:0]);
        endcase
      end
    end
  end

  // clamped sizes
  logic [DW-1:0] w_eff, h_eff;
  logic [1:0]    mw_eff, mh_eff;

  always_comb begin
    w_eff = (width_r == '0) ? 11'd1 :
            ((width_r > 11'(WCAP)) ? 11'(WCAP) : width_r);
    h_eff = (height_r == '0) ? 11'd1 :
            ((height_r > 11'(cecv_pkg::HEIGHT_CAP)) ? 11'(cecv_pkg::HEIGHT_CAP) : height_r);
    mw_eff = (mwidth_r == '0) ? 2'd1 :
             ((mwidth_r > 2'(cecv_pkg::MAX_MASK)) ? 2'(cecv_pkg::MAX_MASK) : mwidth_r);
    mh_eff = (mheight_r == '0) ? 2'd1 :
             ((mheight_r > 2'(cecv_pkg::MAX_MASK)) ? 2'(cecv_pkg::MAX_MASK) : mheight_r);
  end

  // ------------------------------------------------------------------
  // row / column recovery after a width change
  // ------------------------------------------------------------------
  cecv_pkg::div_status_t div_st;
  logic [QW-1:0]         div_quo;
  logic [DW-1:0]         div_rem;
  logic [QW-1:0]         out_idx_r;
  logic                  busy_all;

  cecv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (out_idx_r),
    .divisor   (w_eff),
    .status    (div_st),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign busy_all = start_r || div_st.busy;

  // ------------------------------------------------------------------
  // pipeline handshake
  // ------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic go1, go2, go3, go4, go5;

  assign go5 = !out_v_r || out_tready;
  assign go4 = !s4_v_r || go5;
  assign go3 = !s3_v_r || go4;
  assign go2 = !s2_v_r || go3;
  assign go1 = !s1_v_r || go2;

  assign in_tready = go1 && !busy_all;

  // ------------------------------------------------------------------
  // frame counters and window
  // ------------------------------------------------------------------
  logic [CW-1:0]  in_col_r, in_col_nxt;
  logic [DW-1:0]  in_row_r, in_row_nxt;
  logic [QW-1:0]  out_idx_nxt;
  logic [QW-1:0]  out_row_r, out_row_nxt;
  logic [DW-1:0]  out_col_r, out_col_nxt;
  logic [PW-1:0]  win_r   [3][3];
  logic [PW-1:0]  win_nxt [3][3];

  logic            acc, step, produce, last, in_frame;
  logic [PW-1:0]   pix_eff;
  logic [21:0]     row_prod, total;
  logic [22:0]     k;
  logic [CMPW-1:0] col_inc;
  logic            col_wrap;
  logic [DW:0]     oc_inc;
  logic            oc_wrap;
  edge_flags_t     flags;

  // line store read data, with bypass of a write to the same column
  logic [PW-1:0] old_q, new_q, old_fwd_r, new_fwd_r, top_pix, mid_pix;
  logic          fwd_r;

  assign top_pix = fwd_r ? old_fwd_r : old_q;
  assign mid_pix = fwd_r ? new_fwd_r : new_q;

  // position of the arriving item in the frame
  assign row_prod = in_row_r * w_eff;
  assign total    = w_eff * h_eff;
  assign k        = {1'b0, row_prod} + 23'(in_col_r);
  assign in_frame = k < {1'b0, total};

  assign acc     = in_tvalid && in_tready;
  assign step    = acc && !(in_tuser[0] && in_frame);
  assign pix_eff = (in_tuser[0] || !in_frame) ? '0 : in_tdata;
  assign produce = k >= (23'(w_eff) + 23'd1);
  assign last    = ({2'b0, out_idx_r} + 22'd1) >= total;

  assign col_inc  = CMPW'(in_col_r) + CMPW'(1);
  assign col_wrap = col_inc >= CMPW'(w_eff);
  assign oc_inc   = {1'b0, out_col_r} + 12'd1;
  assign oc_wrap  = oc_inc >= {1'b0, w_eff};

  // border flags of the pixel whose result is released
  always_comb begin
    flags.r_top   = (out_row_r == '0);
    flags.r_bot   = ({1'b0, out_row_r} + 21'd1) >= 21'(h_eff);
    flags.c_left  = (out_col_r == '0);
    flags.c_right = oc_wrap;
  end

  // counter next state
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_idx_nxt = out_idx_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (step) begin
      in_col_nxt = col_wrap ? '0 : CW'(col_inc);
      if (col_wrap && (in_row_r != 11'(cecv_pkg::ROW_SAT))) begin
        in_row_nxt = in_row_r + 1'b1;
      end
      if (produce) begin
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_idx_nxt = '0;
          out_row_nxt = '0;
          out_col_nxt = '0;
        end else if (&out_idx_r) begin
          out_idx_nxt = '0;
          out_row_nxt = '0;
          out_col_nxt = '0;
        end else begin
          out_idx_nxt = out_idx_r + 1'b1;
          out_col_nxt = oc_wrap ? '0 : oc_inc[DW-1:0];
          out_row_nxt = oc_wrap ? out_row_r + 1'b1 : out_row_r;
        end
      end
    end else if (div_st.done && !start_r) begin
      out_row_nxt = div_quo;
      out_col_nxt = div_rem;
    end
  end

  // window shift: new column enters on the right
  always_comb begin
    win_nxt = win_r;
    if (step) begin
      for (int j = 0; j < 3; j++) begin
        win_nxt[j][0] = win_r[j][1];
        win_nxt[j][1] = win_r[j][2];
      end
      win_nxt[0][2] = top_pix;
      win_nxt[1][2] = mid_pix;
      win_nxt[2][2] = pix_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_idx_r <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      fwd_r     <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          win_r[j][i] <= '0;
        end
      end
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_idx_r <= out_idx_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      fwd_r     <= step && (in_col_nxt == in_col_r);
      win_r     <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      old_fwd_r <= mid_pix;
      new_fwd_r <= pix_eff;
    end
  end

  // line stores, read ahead at the next column
  cecv_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_older (
    .clk     (clk),
    .wr_en   (step),
    .wr_addr (in_col_r),
    .wr_data (mid_pix),
    .rd_addr (in_col_nxt),
    .rd_data (old_q)
  );

  cecv_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_newer (
    .clk     (clk),
    .wr_en   (step),
    .wr_addr (in_col_r),
    .wr_data (pix_eff),
    .rd_addr (in_col_nxt),
    .rd_data (new_q)
  );

  // ------------------------------------------------------------------
  // stage 1: window snapshot of a released pixel
  // ------------------------------------------------------------------
  logic          s1_load;
  logic [PW-1:0] s1_win_r [3][3];
  edge_flags_t   s1_flags_r;
  logic          s1_last_r;

  assign s1_load = step && produce;

  // tap position inside the window, with edge replication
  function automatic logic [1:0] tap_sel(input logic [1:0] t, input logic [1:0] msize,
                                         input logic lo, input logic hi);
    logic [1:0] p;
    if (msize == 2'd1) begin
      p = 2'd1;
    end else begin
      case (t)
        2'd0:    p = lo ? 2'd1 : 2'd0;
        2'd1:    p = 2'd1;
        default: p = hi ? 2'd1 : 2'd2;
      endcase
    end
    return p;
  endfunction

  // ------------------------------------------------------------------
  // stage 2: nine products
  // ------------------------------------------------------------------
  logic signed [23:0] s2_prod_r [3][3];
  logic signed [23:0] p_nxt     [3][3];
  logic               s2_last_r;

  always_comb begin
    logic [1:0]         ri, ci;
    logic [PW-1:0]      row_pix [3];
    logic [PW-1:0]      tap;
    logic signed [CFW-1:0] coef;
    logic signed [24:0] prod_full;
    for (int j = 0; j < 3; j++) begin
      ri = tap_sel(2'(j), mh_eff, s1_flags_r.r_top, s1_flags_r.r_bot);
      for (int i = 0; i < 3; i++) begin
        row_pix[i] = (ri == 2'd0) ? s1_win_r[0][i] :
                     ((ri == 2'd1) ? s1_win_r[1][i] : s1_win_r[2][i]);
      end
      for (int i = 0; i < 3; i++) begin
        ci = tap_sel(2'(i), mw_eff, s1_flags_r.c_left, s1_flags_r.c_right);
        tap = (ci == 2'd0) ? row_pix[0] : ((ci == 2'd1) ? row_pix[1] : row_pix[2]);
        coef = signed'(coef_r[j][CFW*i +: CFW]);
        prod_full = $signed({1'b0, tap}) * coef;
        p_nxt[j][i] = ((2'(j) < mh_eff) && (2'(i) < mw_eff)) ? prod_full[23:0] : '0;
      end
    end
  end

  // ------------------------------------------------------------------
  // stage 3: row sums, stage 4: total
  // ------------------------------------------------------------------
  logic signed [25:0] s3_row_r [3];
  logic               s3_last_r;
  logic signed [27:0] s4_sum_r;
  logic               s4_last_r;

  // ------------------------------------------------------------------
  // stage 5: truncate toward zero, bias, clip
  // ------------------------------------------------------------------
  logic signed [28:0] adj, shq;
  logic signed [29:0] val;
  logic [PW-1:0]      pix_res;
  logic [PW-1:0]      out_pix_r;
  logic               out_last_r;

  always_comb begin
    adj = 29'(s4_sum_r) + ((s4_sum_r < 0) ? TRUNC_ADJ : 29'sd0);
    shq = adj >>> FB;
    val = 30'(shq) + 30'(bias_r);
    if (val < 0) begin
      pix_res = '0;
    end else if (val > 30'sd255) begin
      pix_res = 8'd255;
    end else begin
      pix_res = val[PW-1:0];
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (go1) s1_v_r  <= s1_load;
      if (go2) s2_v_r  <= s1_v_r;
      if (go3) s3_v_r  <= s2_v_r;
      if (go4) s4_v_r  <= s3_v_r;
      if (go5) out_v_r <= s4_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (go1 && s1_load) begin
      s1_win_r   <= win_nxt;
      s1_flags_r <= flags;
      s1_last_r  <= last;
    end
    if (go2 && s1_v_r) begin
      s2_prod_r <= p_nxt;
      s2_last_r <= s1_last_r;
    end
    if (go3 && s2_v_r) begin
      for (int j = 0; j < 3; j++) begin
        s3_row_r[j] <= 26'(s2_prod_r[j][0]) + 26'(s2_prod_r[j][1]) + 26'(s2_prod_r[j][2]);
      end
      s3_last_r <= s2_last_r;
    end
    if (go4 && s3_v_r) begin
      s4_sum_r  <= 28'(s3_row_r[0]) + 28'(s3_row_r[1]) + 28'(s3_row_r[2]);
      s4_last_r <= s3_last_r;
    end
    if (go5 && s4_v_r) begin
      out_pix_r  <= pix_res;
      out_last_r <= s4_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  `CECV_ASSERT(a_out_col_in_row, clk, rst_n, !busy_all |-> (out_col_r < w_eff), "output column beyond row width")
  `CECV_ASSERT(a_frame_restart, clk, rst_n, (step && produce && last) |=> ((out_idx_r == '0) && (in_col_r == '0) && (in_row_r == '0)), "counters not cleared after frame end")
  `CECV_ASSERT(a_div_result, clk, rst_n, (div_st.done && !start_r) |-> ((32'(div_quo) * 32'(w_eff) + 32'(div_rem)) == 32'(out_idx_r)), "row and column do not match output index")
  `CECV_ASSERT(a_out_from_pipe, clk, rst_n, $rose(out_v_r) |-> $past(s4_v_r), "result appeared without a filled last stage")

endmodule

[hw/rtl/cecv_ram.sv]
// ---------------------------------------------------------------------------
// cecv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module cecv_ram #(
  parameter int unsigned WIDTH = cecv_pkg::PIX_W,
  parameter int unsigned DEPTH = cecv_pkg::MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/cecv_div.sv]
// ---------------------------------------------------------------------------
// cecv_div
// Restoring divider, one quotient bit per cycle: splits the output index
// into row and column after the row width has changed.
// ---------------------------------------------------------------------------
module cecv_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [cecv_pkg::IDX_W-1:0]        dividend,
  input  logic [cecv_pkg::DIM_W-1:0]        divisor,
  output cecv_pkg::div_status_t             status,
  output logic [cecv_pkg::IDX_W-1:0]        quotient,
  output logic [cecv_pkg::DIM_W-1:0]        remainder
);

  localparam int unsigned QW    = cecv_pkg::IDX_W;
  localparam int unsigned DW    = cecv_pkg::DIM_W;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [QW-1:0]    quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    dsr_r;

  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;

  // one trial subtraction per cycle
  assign trial = {rem_r, quo_r[QW-1]};
  assign fits  = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(QW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out at the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[QW-2:0], fits};
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign status.busy = (cnt_r != '0) || done_r;
  assign status.done = done_r;
  assign quotient    = quo_r;
  assign remainder   = rem_r;

endmodule

[verif/tb_clamped_edge_convolution_3x3_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_clamped_edge_convolution_3x3_unit
// Self-checking bench for the 3x3 replicated-border convolution unit. Frames
// of random pixels go in over the input stream with random gaps. Each item
// taken is run through a bit-true model of the line stores, window and
// mask sum, and every output pixel and its tlast are checked in order.
// Sizes, masks, coefficients and bias are rewritten between frames.
// ---------------------------------------------------------------------------
module tb_clamped_edge_convolution_3x3_unit;
  import cecv_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam logic        KIND_PIXEL   = 1'b0;
  localparam logic        KIND_FLUSH   = 1'b1;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } out_pixel_t;

  // Model of the unit plus the queue of output pixels still owed
  class conv_scoreboard;
    logic [DIM_W-1:0]      width_reg, height_reg;
    logic [MASK_W-1:0]     mask_w_reg, mask_h_reg;
    logic [CFG_DATA_W-1:0] coef_reg [3];
    logic [BIAS_W-1:0]     bias_reg;
    bit [PIX_W-1:0]        older_line [MAX_WIDTH];
    bit [PIX_W-1:0]        newer_line [MAX_WIDTH];
    bit [PIX_W-1:0]        window [3][3];
    int unsigned           col, row, out_idx;
    out_pixel_t            owed_pixels [$];
    int unsigned           n_items, n_flush, n_dropped, n_checked, n_writes, n_errors;

    function new();
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      mask_w_reg = RST_MASK;
      mask_h_reg = RST_MASK;
      coef_reg[0] = '0;
      coef_reg[1] = RST_COEF_MID;
      coef_reg[2] = '0;
      bias_reg = '0;
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      foreach (window[j, i]) window[j][i] = '0;
      col = 0;
      row = 0;
      out_idx = 0;
    endfunction

    task report(string what);
      n_errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function int unsigned clip_range(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      n_writes++;
      case (cfg_reg_t'(idx))
        REG_IMAGE_WIDTH:     width_reg  = data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    height_reg = data[DIM_W-1:0];
        REG_MASK_WIDTH:      mask_w_reg = data[MASK_W-1:0];
        REG_MASK_HEIGHT:     mask_h_reg = data[MASK_W-1:0];
        REG_COEF_ROW_TOP:    coef_reg[0] = data;
        REG_COEF_ROW_MID:    coef_reg[1] = data;
        REG_COEF_ROW_BOTTOM: coef_reg[2] = data;
        REG_BIAS:            bias_reg = data[BIAS_W-1:0];
        default: ;
      endcase
    endfunction

    // One accepted input item: update line stores and window, maybe owe a pixel
    function void convolve_item(logic kind, logic [PIX_W-1:0] pix_in);
      int unsigned w, h, mw, mh, total, k, lc, n, r, c, wr, wc;
      int unsigned row_pick [3];
      int unsigned col_pick [3];
      bit [PIX_W-1:0] pix, top, mid;
      bit signed [COEF_W-1:0] cf;
      bit signed [BIAS_W-1:0] b;
      longint sum, val;
      longint unsigned mag;
      out_pixel_t res;

      w  = clip_range(width_reg, 1, MAX_WIDTH);
      h  = clip_range(height_reg, 1, HEIGHT_CAP);
      mw = clip_range(mask_w_reg, 1, MAX_MASK);
      mh = clip_range(mask_h_reg, 1, MAX_MASK);
      total = w * h;
      k = row * w + col;
      n_items++;
      if (kind == KIND_FLUSH) n_flush++;

      // flush before the frame's last pixel: no effect at all
      if (kind == KIND_FLUSH && k < total) begin
        n_dropped++;
        return;
      end
      // flushes, and pixels in the tail, shift in zero
      pix = (kind == KIND_FLUSH || k >= total) ? '0 : pix_in;

      lc  = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
      top = older_line[lc];
      mid = newer_line[lc];
      older_line[lc] = mid;
      newer_line[lc] = pix;
      for (int j = 0; j < 3; j++) begin
        window[j][0] = window[j][1];
        window[j][1] = window[j][2];
      end
      window[0][2] = top;
      window[1][2] = mid;
      window[2][2] = pix;

      col++;
      if (col >= w) begin
        col = 0;
        if (row < ROW_SAT) row++;
      end
      if (k < w + 1) return;

      // border replication: outside taps fall back on the centre row/column
      n = out_idx;
      r = n / w;
      c = n % w;
      row_pick[0] = (r == 0) ? 1 : 0;
      row_pick[1] = 1;
      row_pick[2] = (r + 1 >= h) ? 1 : 2;
      col_pick[0] = (c == 0) ? 1 : 0;
      col_pick[1] = 1;
      col_pick[2] = (c + 1 >= w) ? 1 : 2;

      sum = 0;
      for (int unsigned j = 0; j < mh; j++) begin
        wr = row_pick[j + 1 - mh / 2];
        for (int unsigned i = 0; i < mw; i++) begin
          wc = col_pick[i + 1 - mw / 2];
          cf = coef_reg[j][COEF_W*i +: COEF_W];
          sum += longint'(window[wr][wc]) * longint'(cf);
        end
      end

      // single truncation toward zero, then bias and clip
      mag = (sum < 0) ? -sum : sum;
      mag = mag >> COEF_FRAC_BITS;
      val = (sum < 0) ? -longint'(mag) : longint'(mag);
      b = bias_reg;
      val += b;
      if (val < 0) val = 0;
      if (val > 255) val = 255;
      res.pixel = val[PIX_W-1:0];

      if (n + 1 >= total) begin
        res.last = 1'b1;
        col = 0;
        row = 0;
        out_idx = 0;
      end else begin
        res.last = 1'b0;
        out_idx = (out_idx + 1) % (1 << IDX_W);
      end
      owed_pixels.push_back(res);
    endfunction

    task check_output(logic [PIX_W-1:0] pixel, logic last);
      out_pixel_t want;
      if (owed_pixels.size() == 0) begin
        report($sformatf("output pixel %0d with tlast %0b arrived with nothing owed",
                         pixel, last));
        return;
      end
      want = owed_pixels.pop_front();
      if (pixel !== want.pixel)
        report($sformatf("result %0d: pixel_out %0d, model %0d", n_checked, pixel, want.pixel));
      if (last !== want.last)
        report($sformatf("result %0d: tlast %0b, model %0b", n_checked, last, want.last));
      n_checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic [0:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  conv_scoreboard        sb = new();
  int unsigned           in_gap_max = 0;
  int unsigned           out_gap_max = 0;
  int unsigned           quiet_cycles = 0;
  int unsigned           items_sent = 0;
  int unsigned           n_settings = 0;
  logic [DIM_W-1:0]      frame_w = RST_WIDTH;
  logic [DIM_W-1:0]      frame_h = RST_HEIGHT;

  clamped_edge_convolution_3x3_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshake monitor: feeds the model and checks results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.convolve_item(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) sb.check_output(out_tdata, out_tlast);
    end
  end

  // Watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: %0d cycles without any handshake", QUIET_LIMIT);
    $display("clamped_edge_convolution_3x3_unit verification failed");
    $finish;
  end

  // Output back-pressure: a random stall before each result
  initial begin : out_ready_drive
    int unsigned gap;
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned cap);
    return (v == 0) ? 1 : ((v > cap) ? cap : v);
  endfunction

  // random bits above the register field, which the unit must ignore
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v,
                                                       int unsigned nbits);
    logic [CFG_DATA_W-1:0] field_mask, junk;
    field_mask = ({CFG_DATA_W{1'b0}} + 1'b1 << nbits) - 1'b1;
    junk = $urandom_range(0, 1) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
    return (junk & ~field_mask) | (v & field_mask);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    int v;
    if ($urandom_range(0, 3) == 0) return COEF_W'($urandom);
    v = $urandom_range(0, 600);
    v -= 300;
    return v[COEF_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coef_row();
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  function automatic logic [BIAS_W-1:0] pick_bias();
    int v;
    if ($urandom_range(0, 3) == 0) return BIAS_W'($urandom);
    v = $urandom_range(0, 128);
    v -= 64;
    return v[BIAS_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_gap_max();
    return ($urandom_range(0, 3) == 0) ? 0 : 10;
  endfunction

  // Register write; cfg_valid stays high for a following write
  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_IMAGE_WIDTH) frame_w = data[DIM_W-1:0];
    if (idx == REG_IMAGE_HEIGHT) frame_h = data[DIM_W-1:0];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
  endtask

  task automatic finish_setup();
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // One input item after a random gap; tvalid is left high on return
  task automatic send_item(logic kind, logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser[0] <= kind;
    in_tdata    <= pix;
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
  endtask

  // Whole frame: pixels with stray early flushes, then the W+1 item tail
  task automatic send_frame(int unsigned w, int unsigned h);
    for (int unsigned p = 0; p < w * h; p++) begin
      if ($urandom_range(0, 15) == 0) send_item(KIND_FLUSH, pick_pixel());
      send_item(KIND_PIXEL, pick_pixel());
    end
    // pixels in the tail are discarded like flushes
    for (int unsigned t = 0; t <= w; t++)
      send_item(($urandom_range(0, 2) == 0) ? KIND_PIXEL : KIND_FLUSH, pick_pixel());
    // flushes between frames are dropped
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_item(KIND_FLUSH, pick_pixel());
    items_sent += w * h + w + 1;
  endtask

  // Wait for every owed result, then let the pipeline empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.owed_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_setup();
    in_gap_max  = pick_gap_max();
    out_gap_max = pick_gap_max();
    if ($urandom_range(0, 3) != 0)
      cfg_write(REG_IMAGE_WIDTH, with_junk(CFG_DATA_W'($urandom_range(0, 12)), DIM_W));
    cfg_write(REG_IMAGE_HEIGHT, with_junk(CFG_DATA_W'($urandom_range(0, 6)), DIM_W));
    if ($urandom_range(0, 1))
      cfg_write(REG_MASK_WIDTH, with_junk(CFG_DATA_W'($urandom_range(0, 3)), MASK_W));
    if ($urandom_range(0, 1))
      cfg_write(REG_MASK_HEIGHT, with_junk(CFG_DATA_W'($urandom_range(0, 3)), MASK_W));
    if ($urandom_range(0, 1)) cfg_write(REG_COEF_ROW_TOP, pick_coef_row());
    if ($urandom_range(0, 1)) cfg_write(REG_COEF_ROW_MID, pick_coef_row());
    if ($urandom_range(0, 1)) cfg_write(REG_COEF_ROW_BOTTOM, pick_coef_row());
    if ($urandom_range(0, 1))
      cfg_write(REG_BIAS, with_junk(CFG_DATA_W'(pick_bias()), BIAS_W));
    finish_setup();
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] dir_pix [12];
    dir_pix = '{8'd0, 8'd255, 8'h55, 8'hAA, 8'd1, 8'd128,
                8'd254, 8'd127, 8'h0F, 8'hF0, 8'd7, 8'd200};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset mask and coefficients on a 4x3 frame, one early flush,
    // one pixel inside the tail
    cfg_write(REG_IMAGE_WIDTH, 48'd4);
    cfg_write(REG_IMAGE_HEIGHT, 48'd3);
    finish_setup();
    for (int p = 0; p < 12; p++) begin
      if (p == 5) send_item(KIND_FLUSH, 8'hA5);
      send_item(KIND_PIXEL, dir_pix[p]);
    end
    send_item(KIND_FLUSH, 8'h00);
    send_item(KIND_PIXEL, 8'hFF);
    repeat (3) send_item(KIND_FLUSH, 8'h3C);
    wait_idle();

    // Directed: zero sizes and masks taken as 1, coefficient and bias extremes
    in_gap_max  = 10;
    out_gap_max = 10;
    cfg_write(REG_IMAGE_WIDTH, 48'd0);
    cfg_write(REG_IMAGE_HEIGHT, 48'd0);
    cfg_write(REG_MASK_WIDTH, 48'd0);
    cfg_write(REG_MASK_HEIGHT, 48'd0);
    cfg_write(REG_COEF_ROW_TOP, 48'h0000_0000_8000);
    cfg_write(REG_BIAS, 48'h0FFF);
    finish_setup();
    send_item(KIND_PIXEL, 8'd255);
    send_item(KIND_FLUSH, 8'd0);
    send_item(KIND_PIXEL, 8'd9);
    wait_idle();
    cfg_write(REG_COEF_ROW_TOP, 48'h0000_0000_7FFF);
    cfg_write(REG_BIAS, 48'h1000);
    finish_setup();
    send_item(KIND_PIXEL, 8'd255);
    repeat (2) send_item(KIND_FLUSH, 8'd0);
    wait_idle();

    // Random settings, small frames
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      random_setup();
      repeat ($urandom_range(1, 3))
        send_frame(eff_dim(frame_w, MAX_WIDTH), eff_dim(frame_h, HEIGHT_CAP));
      wait_idle();
    end

    $display("covered %0d input items (%0d flush, %0d dropped early) and %0d output pixels",
             sb.n_items, sb.n_flush, sb.n_dropped, sb.n_checked);
    $display("%0d register writes over %0d settings, %0d mismatches",
             sb.n_writes, n_settings, sb.n_errors);
    if (sb.n_errors == 0)
      $display("clamped_edge_convolution_3x3_unit verification clean");
    else
      $display("clamped_edge_convolution_3x3_unit verification failed");
    $finish;
  end

endmodule
